FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl modules, used by pdvd_outq
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define PDVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define PDVD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/pdvd_pkg.sv
// types, codes and constants of the position delta varint decoder
package pdvd_pkg;

  localparam int unsigned NumSlots = 3;

  localparam logic [2:0] PH_COUNT    = 3'd0;
  localparam logic [2:0] PH_POSCOUNT = 3'd1;
  localparam logic [2:0] PH_DELTA    = 3'd2;
  localparam logic [2:0] PH_END      = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;

  localparam logic [1:0] KIND_POS    = 2'd0;
  localparam logic [1:0] KIND_DOCEND = 2'd1;
  localparam logic [1:0] KIND_OK     = 2'd2;
  localparam logic [1:0] KIND_ERR    = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNC     = 2'd1;
  localparam logic [1:0] ERR_TRAIL     = 2'd2;
  localparam logic [1:0] ERR_MALFORMED = 2'd3;

  localparam logic [2:0] MaxVarintBytes = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] doc_index;
    logic [31:0] position;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  // all results caused by one byte
  typedef struct packed {
    result_t [NumSlots-1:0] slot;
    logic [1:0]             count;
  } bundle_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [31:0] doc,
                                        logic [31:0] pos, logic [1:0] err);
    result_t r;
    r.kind       = kind;
    r.doc_index  = doc;
    r.position   = pos;
    r.error_code = err;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/core/pdvd_decode.sv
// input register, parse state and single pass varint decode
module pdvd_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        payload_byte_i,
  input  logic              end_of_payload_i,
  input  logic              can_load_i,
  output logic              load_o,
  output pdvd_pkg::bundle_t bundle_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        eop_q;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] docs_q, docs_d;
  logic [31:0] posr_q, posr_d;
  logic [31:0] cur_q, cur_d;
  logic [31:0] run_q, run_d;
  logic        first_q, first_d;

  logic [31:0] acc_or;
  logic [31:0] value;
  logic        doc_done;
  logic        closed_all;
  logic [1:0]  n;
  pdvd_pkg::result_t [pdvd_pkg::NumSlots-1:0] res;
  logic        adv;

  function automatic logic [31:0] shift7(logic [6:0] b, logic [2:0] c);
    logic [31:0] w;
    w = {25'd0, b};
    unique case (c)
      3'd0:    shift7 = w;
      3'd1:    shift7 = w << 7;
      3'd2:    shift7 = w << 14;
      3'd3:    shift7 = w << 21;
      3'd4:    shift7 = w << 28;
      default: shift7 = '0;
    endcase
  endfunction

  assign adv        = in_valid_q && ((n == 2'd0) || can_load_i);
  assign in_stall_o = in_valid_q && !adv;
  assign load_o     = adv && (n != 2'd0);

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    docs_d     = docs_q;
    posr_d     = posr_q;
    cur_d      = cur_q;
    run_d      = run_q;
    first_d    = first_q;
    n          = 2'd0;
    res        = '0;
    doc_done   = 1'b0;
    closed_all = 1'b0;
    acc_or     = acc_q | shift7(byte_q[6:0], cnt_q);
    value      = acc_or;

    if (phase_q >= pdvd_pkg::PH_SKIP) begin
      if (eop_q) begin
        phase_d = pdvd_pkg::PH_COUNT;
        acc_d   = '0;
        cnt_d   = '0;
        docs_d  = '0;
        posr_d  = '0;
        cur_d   = '0;
        run_d   = '0;
        first_d = 1'b1;
      end
    end else if (phase_q == pdvd_pkg::PH_END) begin
      res[n] = pdvd_pkg::mk_result(pdvd_pkg::KIND_ERR, cur_q, '0, pdvd_pkg::ERR_TRAIL);
      n      = n + 2'd1;
      phase_d = pdvd_pkg::PH_SKIP;
    end else if (byte_q[7]) begin
      // continuation byte
      acc_d = acc_or;
      if (cnt_q >= pdvd_pkg::MaxVarintBytes) begin
        res[n] = pdvd_pkg::mk_result(pdvd_pkg::KIND_ERR, cur_q, '0,
                                     pdvd_pkg::ERR_MALFORMED);
        n       = n + 2'd1;
        phase_d = pdvd_pkg::PH_SKIP;
      end else begin
        cnt_d = cnt_q + 3'd1;
        if (eop_q) begin
          res[n] = pdvd_pkg::mk_result(pdvd_pkg::KIND_ERR, cur_q, '0,
                                       pdvd_pkg::ERR_TRUNC);
          n = n + 2'd1;
        end
      end
    end else begin
      acc_d = '0;
      cnt_d = '0;
      if (phase_q == pdvd_pkg::PH_COUNT) begin
        docs_d = value;
        cur_d  = '0;
        if (value == '0) closed_all = 1'b1;
        else phase_d = pdvd_pkg::PH_POSCOUNT;
      end else begin
        if (phase_q == pdvd_pkg::PH_POSCOUNT) begin
          posr_d  = value;
          first_d = 1'b1;
          run_d   = '0;
          if (value == '0) doc_done = 1'b1;
          else phase_d = pdvd_pkg::PH_DELTA;
        end else begin
          // first delta of a document is absolute
          run_d   = first_q ? value : run_q + value;
          first_d = 1'b0;
          res[n]  = pdvd_pkg::mk_result(pdvd_pkg::KIND_POS, cur_q, run_d,
                                        pdvd_pkg::ERR_NONE);
          n       = n + 2'd1;
          posr_d  = posr_q - 32'd1;
          if (posr_d == '0) doc_done = 1'b1;
        end
        if (doc_done) begin
          res[n]  = pdvd_pkg::mk_result(pdvd_pkg::KIND_DOCEND, cur_q, '0,
                                        pdvd_pkg::ERR_NONE);
          n       = n + 2'd1;
          cur_d   = cur_q + 32'd1;
          docs_d  = docs_q - 32'd1;
          first_d = 1'b1;
          if (docs_d == '0) closed_all = 1'b1;
          else phase_d = pdvd_pkg::PH_POSCOUNT;
        end
      end
      if (closed_all) begin
        if (eop_q) begin
          res[n] = pdvd_pkg::mk_result(pdvd_pkg::KIND_OK, cur_d, '0, pdvd_pkg::ERR_NONE);
          n      = n + 2'd1;
        end else begin
          phase_d = pdvd_pkg::PH_END;
        end
      end else if (eop_q) begin
        res[n] = pdvd_pkg::mk_result(pdvd_pkg::KIND_ERR, cur_d, '0, pdvd_pkg::ERR_TRUNC);
        n      = n + 2'd1;
      end
    end

    // any result on a flagged byte means ok or error: start over
    if (eop_q && (n != 2'd0)) begin
      phase_d = pdvd_pkg::PH_COUNT;
      acc_d   = '0;
      cnt_d   = '0;
      docs_d  = '0;
      posr_d  = '0;
      cur_d   = '0;
      run_d   = '0;
      first_d = 1'b1;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  assign bundle_o.slot  = res;
  assign bundle_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= payload_byte_i;
      eop_q  <= end_of_payload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pdvd_pkg::PH_COUNT;
      acc_q   <= '0;
      cnt_q   <= '0;
      docs_q  <= '0;
      posr_q  <= '0;
      cur_q   <= '0;
      run_q   <= '0;
      first_q <= 1'b1;
    end else if (adv) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      docs_q  <= docs_d;
      posr_q  <= posr_d;
      cur_q   <= cur_d;
      run_q   <= run_d;
      first_q <= first_d;
    end
  end

endmodule

FILE: rtl/core/pdvd_outq.sv
// result register holding one byte's results, handed out one per transaction
`include "assert_macros.svh"

module pdvd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  pdvd_pkg::bundle_t bundle_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pdvd_pkg::result_t result_o
);

  pdvd_pkg::bundle_t bundle_q;
  logic              bvalid_q;
  logic [1:0]        idx_q;
  logic              take;
  logic              take_last;

  assign out_valid_o = bvalid_q;
  assign result_o    = bundle_q.slot[idx_q];
  assign take        = bvalid_q && !out_stall_i;
  assign take_last   = take && (idx_q == bundle_q.count - 2'd1);
  assign can_load_o  = !bvalid_q || take_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= '0;
    end else if (load_i) begin
      bvalid_q <= 1'b1;
      idx_q    <= '0;
    end else if (take_last) begin
      bvalid_q <= 1'b0;
      idx_q    <= '0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  `PDVD_ASSERT(a_load_has_room, !load_i || can_load_o, "bundle loaded over pending results")
  `PDVD_ASSERT(a_index_in_range, !bvalid_q || (idx_q < bundle_q.count),
               "result index beyond bundle count")
  `PDVD_ASSERT(a_final_slot_marked, !bvalid_q || bundle_q.slot[bundle_q.count - 2'd1].last,
               "final result of a byte lacks last flag")
  `PDVD_ASSERT_NEXT(a_partial_take_advances, take && !take_last && !load_i,
                    bvalid_q && (idx_q == $past(idx_q) + 2'd1),
                    "index did not advance after a transaction")

endmodule

FILE: rtl/core/position_delta_varint_decoder.sv
// top level of the delta coded varint position list decoder
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  input    | in        | in_valid_i / in_stall_o | payload_byte_i, end_of_payload_i
//  result   | out       | out_valid_o / out_stall_i | kind, doc_index, position, error_code, last
//
// a byte is registered, decoded combinationally into up to three results and held in the
// result register once that can take them; its first result is offered from there
// a byte causing several results holds the result register until each is taken, so while
// the output does not stall the input takes one byte per cycle as long as each byte yields at
// most one result, and bytes with no result pass at one per cycle; the single result register
// sets that figure; reset returns the parser to expecting a document count and empties both
// registers; out_stall_i holds the current result; a registered byte with results then
// waits and stalls input

module position_delta_varint_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        end_of_payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] doc_index_o,
  output logic [31:0] position_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);

  pdvd_pkg::bundle_t bundle;
  pdvd_pkg::result_t result;
  logic              can_load;
  logic              load;

  pdvd_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .end_of_payload_i (end_of_payload_i),
    .can_load_i       (can_load),
    .load_o           (load),
    .bundle_o         (bundle)
  );

  pdvd_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign kind_o       = result.kind;
  assign doc_index_o  = result.doc_index;
  assign position_o   = result.position;
  assign error_code_o = result.error_code;
  assign last_o       = result.last;

endmodule

FILE: sim/pdvd_checker.sv
// checker for the varint position decoder: predicts every result and compares on the output
`timescale 1ns / 1ps

module pdvd_checker
  import pdvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        end_of_payload_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] doc_index_i,
  input  logic [31:0] position_i,
  input  logic [1:0]  error_code_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned parsed_bytes_o
);

  // parser state of the prediction
  logic [2:0]  phase_q;
  logic [31:0] acc_q;
  logic [2:0]  nbytes_q;
  logic [31:0] docs_left_q;
  logic [31:0] pos_left_q;
  logic [31:0] doc_idx_q;
  logic [31:0] run_pos_q;
  logic        first_q;

  result_t pending_results[$];

  task automatic restart_parser();
    phase_q     = PH_COUNT;
    acc_q       = '0;
    nbytes_q    = '0;
    docs_left_q = '0;
    pos_left_q  = '0;
    doc_idx_q   = '0;
    run_pos_q   = '0;
    first_q     = 1'b1;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic [31:0] pos,
                             input logic [1:0] code);
    result_t r;
    r.kind       = kind;
    r.doc_index  = doc_idx_q;
    r.position   = pos;
    r.error_code = code;
    r.last       = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic report_error(input logic [1:0] code, input logic eop);
    push_result(KIND_ERR, '0, code);
    if (eop) begin
      restart_parser();
    end else begin
      phase_q = PH_SKIP;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eop);
    logic [31:0] value;
    logic [31:0] part;
    logic        closed_all;
    logic        doc_done;
    int unsigned n_before;
    result_t     r;
    n_before   = pending_results.size();
    closed_all = 1'b0;
    doc_done   = 1'b0;
    part       = {25'd0, b[6:0]};
    if (phase_q >= PH_SKIP) begin
      if (eop) begin
        restart_parser();
      end
    end else if (phase_q == PH_END) begin
      parsed_bytes_o++;
      report_error(ERR_TRAIL, eop);
    end else begin
      parsed_bytes_o++;
      acc_q = acc_q | (part << (7 * nbytes_q));
      if (b[7]) begin
        if (nbytes_q >= MaxVarintBytes) begin
          report_error(ERR_MALFORMED, eop);
        end else begin
          nbytes_q++;
          if (eop) begin
            report_error(ERR_TRUNC, eop);
          end
        end
      end else begin
        value    = acc_q;
        acc_q    = '0;
        nbytes_q = '0;
        if (phase_q == PH_COUNT) begin
          docs_left_q = value;
          doc_idx_q   = '0;
          if (value == 0) begin
            closed_all = 1'b1;
          end else begin
            phase_q = PH_POSCOUNT;
          end
        end else begin
          if (phase_q == PH_POSCOUNT) begin
            pos_left_q = value;
            first_q    = 1'b1;
            run_pos_q  = '0;
            if (value == 0) begin
              doc_done = 1'b1;
            end else begin
              phase_q = PH_DELTA;
            end
          end else begin
            // first delta of a document is absolute, later ones wrap at 32 bits
            run_pos_q = first_q ? value : run_pos_q + value;
            first_q   = 1'b0;
            push_result(KIND_POS, run_pos_q, ERR_NONE);
            pos_left_q--;
            if (pos_left_q == 0) begin
              doc_done = 1'b1;
            end
          end
          if (doc_done) begin
            push_result(KIND_DOCEND, '0, ERR_NONE);
            doc_idx_q++;
            docs_left_q--;
            first_q = 1'b1;
            if (docs_left_q == 0) begin
              closed_all = 1'b1;
            end else begin
              phase_q = PH_POSCOUNT;
            end
          end
        end
        if (closed_all) begin
          if (eop) begin
            push_result(KIND_OK, '0, ERR_NONE);
            restart_parser();
          end else begin
            phase_q = PH_END;
          end
        end else if (eop) begin
          report_error(ERR_TRUNC, eop);
        end
      end
    end
    if (pending_results.size() > n_before) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  task automatic log_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      log_failure($sformatf("unexpected result: kind %0d doc %0d pos %0h err %0d last %0b",
                            kind_i, doc_index_i, position_i, error_code_i, last_i));
    end else begin
      want = pending_results.pop_front();
      if (want.kind !== kind_i || want.doc_index !== doc_index_i ||
          want.position !== position_i || want.error_code !== error_code_i ||
          want.last !== last_i) begin
        log_failure($sformatf({"result mismatch: expected kind %0d doc %0d pos %0h err %0d ",
                               "last %0b, got kind %0d doc %0d pos %0h err %0d last %0b"},
                              want.kind, want.doc_index, want.position, want.error_code,
                              want.last, kind_i, doc_index_i, position_i, error_code_i,
                              last_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parser();
      pending_results.delete();
      fail_count_o   = 0;
      parsed_bytes_o = 0;
      pending_o      = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_result();
      end
      if (in_valid_i && !in_stall_i) begin
        decode_byte(payload_byte_i, end_of_payload_i);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// top of the decoder testbench: clock, reset, byte stimulus, result sink and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int ClkPeriod     = 20;
  localparam int ItemTarget    = 250;
  localparam int HoldCycles    = 200;
  localparam int TimeoutCycles = 200_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  payload_byte;
  logic        end_of_payload;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [31:0] doc_index;
  logic [31:0] position;
  logic [1:0]  error_code;
  logic        last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned parsed_bytes;

  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_req;
  logic [7:0]  payload_q[$];

  position_delta_varint_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .payload_byte_i  (payload_byte),
    .end_of_payload_i(end_of_payload),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .doc_index_o     (doc_index),
    .position_o      (position),
    .error_code_o    (error_code),
    .last_o          (last)
  );

  pdvd_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .payload_byte_i  (payload_byte),
    .end_of_payload_i(end_of_payload),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .kind_i          (kind),
    .doc_index_i     (doc_index),
    .position_i      (position),
    .error_code_i    (error_code),
    .last_i          (last),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .parsed_bytes_o  (parsed_bytes)
  );

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // varint of the given byte length (raised to the bytes needed, at most five), padded with zero groups
  task automatic put_varint(input logic [31:0] value, input int nbytes);
    logic [7:0]  b;
    logic [31:0] rest;
    int          need;
    need = 1;
    rest = value >> 7;
    while (rest != 0) begin
      need++;
      rest = rest >> 7;
    end
    if (nbytes < need) nbytes = need;
    if (nbytes > 5) nbytes = 5;
    rest = value;
    for (int i = 0; i < nbytes; i++) begin
      b    = {1'b0, rest[6:0]};
      rest = rest >> 7;
      // fifth byte: bits above bit 31 are dropped by the parser
      if (i == 4) b[6:4] = 3'($urandom_range(7));
      if (i < nbytes - 1) b[7] = 1'b1;
      payload_q.insert(payload_q.size(), b);
    end
  endtask

  function automatic logic [31:0] rand_value();
    int unsigned bits;
    bits = $urandom_range(32);
    return (bits == 0) ? 32'd0 : ($urandom() >> (32 - bits));
  endfunction

  task automatic build_payload();
    int ndocs;
    int npos;
    int pick;
    int cut;
    int idx;
    payload_q.delete();
    ndocs = $urandom_range(3);
    put_varint(ndocs, $urandom_range(1, 2));
    for (int d = 0; d < ndocs; d++) begin
      npos = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
      put_varint(npos, $urandom_range(1, 2));
      for (int p = 0; p < npos; p++) begin
        put_varint(rand_value(), $urandom_range(1, 5));
      end
    end
    pick = $urandom_range(99);
    if (pick >= 65 && pick < 75 && payload_q.size() > 1) begin
      // truncated payload
      cut = $urandom_range(1, payload_q.size() - 1);
      while (payload_q.size() > cut) void'(payload_q.pop_back());
    end else if (pick >= 75 && pick < 83) begin
      // trailing bytes
      repeat ($urandom_range(1, 3)) payload_q.insert(payload_q.size(), 8'($urandom_range(255)));
    end else if (pick >= 83 && pick < 90) begin
      // overlong varint somewhere in the stream
      idx = $urandom_range(payload_q.size() - 1);
      repeat (5) payload_q.insert(idx, 8'h80 | 8'($urandom_range(127)));
    end else if (pick >= 90) begin
      payload_q.delete();
      repeat ($urandom_range(1, 8)) payload_q.insert(payload_q.size(), 8'($urandom_range(255)));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    payload_byte   <= b;
    end_of_payload <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_payload();
    for (int i = 0; i < payload_q.size(); i++) begin
      send_byte(payload_q[i], i == payload_q.size() - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // result side: random stall, plus one long hold-off while the sender keeps going
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    payload_byte   <= 8'h00;
    end_of_payload <= 1'b0;
    hold_req       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero document count, then ok
    payload_q = {8'h00};
    send_payload();
    // trailing byte on the last byte restarts at once
    payload_q = {8'h00, 8'h55};
    send_payload();
    // trailing byte mid payload, remainder skipped
    payload_q = {8'h00, 8'hAA, 8'h3C};
    send_payload();
    // overlong varint on the last byte
    payload_q = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_payload();
    // open varint at payload end
    payload_q = {8'h80};
    send_payload();
    // full range delta then wrap, document still missing at the end
    payload_q = {8'h02, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h02};
    send_payload();
    // empty document, then position, document end and ok on one byte
    payload_q = {8'h02, 8'h00, 8'h01, 8'h7F};
    send_payload();
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req <= 1'b1;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      while (parsed_bytes < (phase + 1) * ItemTarget / 4 + 24) begin
        build_payload();
        send_payload();
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

endmodule
